// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the core checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/mcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpu_pkg
// types, constants and helper functions of the microsequenced 16-bit core
// ----------------------------------------------------------------------------
package mcpu_pkg;

   localparam int ADDR_BITS  = 16;
   localparam int BANK_BITS  = ADDR_BITS - 1;
   localparam int BANK_DEPTH = 1 << BANK_BITS;
   localparam int NUM_REGS   = 16;
   localparam int REG_BITS   = $clog2(NUM_REGS);

   typedef enum logic [1:0] {
      OPC_LOAD    = 2'd0,
      OPC_ADVANCE = 2'd1,
      OPC_RESET   = 2'd2,
      OPC_NONE    = 2'd3
   } opc_type;

   typedef enum logic [1:0] {
      PH_FETCH   = 2'd0,
      PH_OPERAND = 2'd1,
      PH_EXECUTE = 2'd2,
      PH_IRQ     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      MODE_IMM = 2'd0,
      MODE_REG = 2'd1,
      MODE_IND = 2'd2,
      MODE_IDX = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      HALT_RUN     = 2'd0,
      HALT_ILLEGAL = 2'd1,
      HALT_STRAY   = 2'd2,
      HALT_SPARE   = 2'd3
   } halt_type;

   typedef enum logic [1:0] {
      CLS_TWO    = 2'd0,
      CLS_ONE    = 2'd1,
      CLS_BRANCH = 2'd2,
      CLS_NOP    = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_EXEC  = 2'd2,
      ST_SPARE = 2'd3
   } state_type;

   localparam int FL_C = 3;
   localparam int FL_Z = 2;
   localparam int FL_S = 1;
   localparam int FL_V = 0;

   localparam logic [9:0]  LIM_ONE    = 10'h20E;
   localparam logic [7:0]  LIM_BRANCH = 8'hA7;
   localparam logic [15:0] LIM_NOP    = 16'hC012;

   typedef struct packed {
      logic [1:0]  run_status;
      logic [1:0]  phase_now;
      logic [3:0]  impulse_now;
      logic [15:0] program_counter;
      logic [15:0] instruction_word;
      logic [3:0]  flag_bits;
      logic        mem_write_valid;
      logic [15:0] mem_write_address;
      logic [15:0] mem_write_word;
      logic        reg_write_valid;
      logic [3:0]  reg_write_index;
      logic [15:0] reg_write_data;
   } rsp_type;

   // returns {carry, overflow, sum}
   function automatic logic [17:0] add16(input logic [15:0] a, input logic [15:0] b,
                                         input logic cin);
      logic [16:0] s;
      logic        v;
      s = {1'b0, a} + {1'b0, b} + {16'd0, cin};
      v = ~(a[15] ^ b[15]) & (a[15] ^ s[15]);
      return {s[16], v, s[15:0]};
   endfunction

   function automatic logic [3:0] zs(input logic [3:0] f, input logic [15:0] r);
      return {f[FL_C], (r == 16'd0), r[15], f[FL_V]};
   endfunction

endpackage

// ===== rtl/core/mcpu_if.sv =====
// ----------------------------------------------------------------------------
// mcpu_if
// step request and step response channels of the core
// ----------------------------------------------------------------------------
interface mcpu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] load_address;
   logic [7:0]  load_data;

   modport source (output valid, opcode, load_address, load_data, input ready);
   modport sink   (input valid, opcode, load_address, load_data, output ready);
endinterface

interface mcpu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  run_status;
   logic [1:0]  phase_now;
   logic [3:0]  impulse_now;
   logic [15:0] program_counter;
   logic [15:0] instruction_word;
   logic [3:0]  flag_bits;
   logic        mem_write_valid;
   logic [15:0] mem_write_address;
   logic [15:0] mem_write_word;
   logic        reg_write_valid;
   logic [3:0]  reg_write_index;
   logic [15:0] reg_write_data;

   modport source (output valid, run_status, phase_now, impulse_now, program_counter,
                   instruction_word, flag_bits, mem_write_valid, mem_write_address,
                   mem_write_word, reg_write_valid, reg_write_index, reg_write_data,
                   input ready);
   modport sink   (input valid, run_status, phase_now, impulse_now, program_counter,
                   instruction_word, flag_bits, mem_write_valid, mem_write_address,
                   mem_write_word, reg_write_valid, reg_write_index, reg_write_data,
                   output ready);
endinterface

// ===== rtl/core/microsequenced_cpu16_core.sv =====
// ----------------------------------------------------------------------------
// microsequenced_cpu16_core
// 16-bit microsequenced cpu: one micro-impulse, byte load or core reset per beat
// ----------------------------------------------------------------------------
// req carries one step beat: load a memory byte, advance one impulse or reset
// the core registers. rsp returns one beat per request with the core state
// after the step and any register or memory word written by it.
// a request is accepted in idle, where the byte banks and the register file
// are read at the current address and operand index (synchronous reads);
// execute then computes the impulse, writes back and loads the response
// register. req is ready only in idle, so a new request is taken only after
// the previous one has left execute; the synchronous reads set this pace.
// the response register holds a finished beat while the next request is read;
// if rsp stalls, the second request waits in execute until the register frees.
// after reset the byte memory is swept to zero, one even and one odd byte a
// cycle, during which req is not ready. a core reset beat clears registers
// and flags but keeps memory.
// ----------------------------------------------------------------------------
module microsequenced_cpu16_core (
   input logic        clock,
   input logic        reset,
   mcpu_req_if.sink   req,
   mcpu_rsp_if.source rsp
);

   localparam int BB = mcpu_pkg::BANK_BITS;
   localparam int RB = mcpu_pkg::REG_BITS;

   mcpu_pkg::state_type state_ff, state_in;
   logic [BB-1:0] clr_ff, clr_in;

   logic [7:0] mem_even [mcpu_pkg::BANK_DEPTH];
   logic [7:0] mem_odd  [mcpu_pkg::BANK_DEPTH];
   logic [15:0] gr [mcpu_pkg::NUM_REGS];
   logic [mcpu_pkg::NUM_REGS-1:0] gr_vld_ff, gr_vld_in;

   logic [7:0] rd_even_ff, rd_odd_ff;
   logic       rd_swap_ff;
   logic [15:0] regrd_ff;
   logic       regvld_ff;

   logic [1:0]  opc_ff;
   logic [15:0] ladr_ff;
   logic [7:0]  ldat_ff;

   logic [15:0] pc_ff, pc_in, ir_ff, ir_in, t_ff, t_in, adr_ff, adr_in, mdr_ff, mdr_in;
   logic [3:0]  flags_ff, flags_in, imp_ff, imp_in;
   mcpu_pkg::phase_type phase_ff, phase_in;
   mcpu_pkg::class_type cls_ff, cls_in;
   mcpu_pkg::halt_type  halt_ff, halt_in;

   mcpu_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_vld_ff, rsp_vld_in;

   logic accept, fire;
   logic [BB-1:0] rd_hi, rd_idx_even, ridx_unused;
   logic [RB-1:0] reg_ridx;
   logic [3:0] oimp;

   logic we_even, we_odd;
   logic [BB-1:0] wi_even, wi_odd;
   logic [7:0] wd_even, wd_odd;
   logic gr_we;
   logic [RB-1:0] gr_wi;
   logic [15:0] gr_wd;

   assign accept  = req.valid && req.ready;
   assign req.ready = (state_ff == mcpu_pkg::ST_IDLE);
   assign fire    = (state_ff == mcpu_pkg::ST_EXEC) && (!rsp_vld_ff || rsp.ready);

   // read addressing from the current core state
   assign rd_hi       = adr_ff[mcpu_pkg::ADDR_BITS-1:1];
   assign rd_idx_even = adr_ff[0] ? rd_hi + BB'(1) : rd_hi;
   assign ridx_unused = '0;
   assign oimp = (ir_ff[15] && imp_ff < 4'd6) ? 4'd6 : imp_ff;
   assign reg_ridx = (phase_ff == mcpu_pkg::PH_OPERAND && (oimp == 4'd1 || oimp == 4'd3))
                     ? ir_ff[9:6] : ir_ff[3:0];

   always_ff @(posedge clock) begin
      if (we_even) mem_even[wi_even] <= wd_even;
      if (we_odd)  mem_odd[wi_odd]   <= wd_odd;
      rd_even_ff <= mem_even[rd_idx_even];
      rd_odd_ff  <= mem_odd[rd_hi | ridx_unused];
      rd_swap_ff <= adr_ff[0];
      if (gr_we) gr[gr_wi] <= gr_wd;
      regrd_ff  <= gr[reg_ridx];
      regvld_ff <= gr_vld_ff[reg_ridx];
      if (accept) begin
         opc_ff  <= req.opcode;
         ladr_ff <= req.load_address;
         ldat_ff <= req.load_data;
      end
      if (fire) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mcpu_pkg::ST_CLEAR;
         clr_ff     <= '0;
         gr_vld_ff  <= '0;
         rsp_vld_ff <= 1'b0;
         pc_ff <= '0; ir_ff <= '0; t_ff <= '0; adr_ff <= '0; mdr_ff <= '0;
         flags_ff <= '0; imp_ff <= 4'd1;
         phase_ff <= mcpu_pkg::PH_FETCH;
         cls_ff   <= mcpu_pkg::CLS_TWO;
         halt_ff  <= mcpu_pkg::HALT_RUN;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         gr_vld_ff  <= gr_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (fire) begin
            pc_ff <= pc_in; ir_ff <= ir_in; t_ff <= t_in; adr_ff <= adr_in;
            mdr_ff <= mdr_in; flags_ff <= flags_in; imp_ff <= imp_in;
            phase_ff <= phase_in; cls_ff <= cls_in; halt_ff <= halt_in;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      case (state_ff)
         mcpu_pkg::ST_CLEAR: begin
            clr_in = clr_ff + BB'(1);
            if (clr_ff == '1) state_in = mcpu_pkg::ST_IDLE;
         end
         mcpu_pkg::ST_IDLE: begin
            if (accept) state_in = mcpu_pkg::ST_EXEC;
         end
         mcpu_pkg::ST_EXEC: begin
            if (fire) begin
               state_in   = mcpu_pkg::ST_IDLE;
               rsp_vld_in = 1'b1;
            end
         end
         default: state_in = mcpu_pkg::ST_IDLE;
      endcase
   end

   // one step of the core
   logic [15:0] word, regv, r, off;
   logic [17:0] sum;
   logic        bad, take, mw_v, st_res;
   logic [15:0] mw_a, mw_d;
   mcpu_pkg::mode_type ms, md;
   logic [3:0] op4;
   logic [2:0] op3;

   assign word = rd_swap_ff ? {rd_even_ff, rd_odd_ff} : {rd_odd_ff, rd_even_ff};
   assign regv = regvld_ff ? regrd_ff : 16'd0;
   assign ms   = mcpu_pkg::mode_type'(ir_ff[11:10]);
   assign md   = mcpu_pkg::mode_type'(ir_ff[5:4]);

   always_comb begin
      pc_in = pc_ff; ir_in = ir_ff; t_in = t_ff; adr_in = adr_ff; mdr_in = mdr_ff;
      flags_in = flags_ff; imp_in = imp_ff; phase_in = phase_ff; cls_in = cls_ff;
      halt_in = halt_ff; gr_vld_in = gr_vld_ff;
      gr_we = 1'b0; gr_wi = ir_ff[3:0]; gr_wd = 16'd0;
      mw_v = 1'b0; mw_a = adr_ff; mw_d = mdr_ff;
      r = 16'd0; sum = 18'd0; bad = 1'b0; take = 1'b0; st_res = 1'b0;
      off = {{8{ir_ff[7]}}, ir_ff[7:0]};
      op4 = ir_ff[9:6]; op3 = ir_ff[14:12];
      case (mcpu_pkg::opc_type'(opc_ff))
         mcpu_pkg::OPC_RESET: begin
            pc_in = '0; ir_in = '0; t_in = '0; adr_in = '0; mdr_in = '0;
            flags_in = '0; cls_in = mcpu_pkg::CLS_TWO; halt_in = mcpu_pkg::HALT_RUN;
            phase_in = mcpu_pkg::PH_FETCH; imp_in = 4'd1; gr_vld_in = '0;
         end
         mcpu_pkg::OPC_ADVANCE: begin
            if (halt_ff == mcpu_pkg::HALT_RUN) begin
               imp_in = imp_ff + 4'd1;
               case (phase_ff)
                  mcpu_pkg::PH_FETCH: begin
                     case (imp_ff)
                        4'd1: adr_in = pc_ff;
                        4'd2: begin
                           ir_in = word;
                           pc_in = pc_ff + 16'd2;
                        end
                        4'd3: begin
                           if (!ir_ff[15]) begin
                              cls_in = mcpu_pkg::CLS_TWO;
                              bad = ir_ff[15:12] > 4'd6;
                           end else if (ir_ff[14:13] == 2'b00) begin
                              cls_in = mcpu_pkg::CLS_ONE;
                              bad = ir_ff[15:6] > mcpu_pkg::LIM_ONE;
                           end else if (ir_ff[14:13] == 2'b01) begin
                              cls_in = mcpu_pkg::CLS_BRANCH;
                              bad = ir_ff[15:8] > mcpu_pkg::LIM_BRANCH;
                           end else if (ir_ff[14:13] == 2'b10) begin
                              cls_in = mcpu_pkg::CLS_NOP;
                              bad = ir_ff > mcpu_pkg::LIM_NOP;
                           end else begin
                              bad = 1'b1;
                           end
                           if (bad) begin
                              halt_in = mcpu_pkg::HALT_ILLEGAL;
                           end else begin
                              phase_in = (cls_in == mcpu_pkg::CLS_TWO ||
                                          cls_in == mcpu_pkg::CLS_ONE)
                                         ? mcpu_pkg::PH_OPERAND : mcpu_pkg::PH_EXECUTE;
                              imp_in = 4'd1;
                           end
                        end
                        default: halt_in = mcpu_pkg::HALT_STRAY;
                     endcase
                  end
                  mcpu_pkg::PH_OPERAND: begin
                     imp_in = oimp + 4'd1;
                     case (oimp)
                        4'd1: begin
                           if (ms == mcpu_pkg::MODE_IMM || ms == mcpu_pkg::MODE_IDX) begin
                              adr_in = pc_ff;
                              pc_in  = pc_ff + 16'd2;
                           end else if (ms == mcpu_pkg::MODE_REG) begin
                              t_in   = regv;
                              imp_in = 4'd6;
                           end else begin
                              adr_in = regv;
                           end
                        end
                        4'd2, 4'd4: mdr_in = word;
                        4'd3: begin
                           if (ms == mcpu_pkg::MODE_IDX) begin
                              adr_in = regv + mdr_ff;
                           end else if (ms != mcpu_pkg::MODE_REG) begin
                              t_in   = mdr_ff;
                              imp_in = 4'd6;
                           end
                        end
                        4'd5: t_in = mdr_ff;
                        4'd6: begin
                           if (md == mcpu_pkg::MODE_IMM || md == mcpu_pkg::MODE_IDX) begin
                              adr_in = pc_ff;
                              pc_in  = pc_ff + 16'd2;
                           end else if (md == mcpu_pkg::MODE_REG) begin
                              mdr_in   = regv;
                              phase_in = mcpu_pkg::PH_EXECUTE;
                              imp_in   = 4'd1;
                           end else begin
                              adr_in = regv;
                           end
                        end
                        4'd7: begin
                           mdr_in = word;
                           if (md == mcpu_pkg::MODE_IMM || md == mcpu_pkg::MODE_IND) begin
                              phase_in = mcpu_pkg::PH_EXECUTE;
                              imp_in   = 4'd1;
                           end
                        end
                        4'd8: adr_in = regv + mdr_ff;
                        4'd9: begin
                           mdr_in   = word;
                           phase_in = mcpu_pkg::PH_EXECUTE;
                           imp_in   = 4'd1;
                        end
                        default: halt_in = mcpu_pkg::HALT_STRAY;
                     endcase
                  end
                  mcpu_pkg::PH_EXECUTE: begin
                     case (cls_ff)
                        mcpu_pkg::CLS_TWO: begin
                           if (imp_ff == 4'd1) begin
                              st_res = 1'b1;
                              case (op3)
                                 3'd0: r = t_ff;
                                 3'd1: sum = mcpu_pkg::add16(t_ff, mdr_ff, 1'b0);
                                 3'd2, 3'd3: sum = mcpu_pkg::add16(mdr_ff, ~t_ff, 1'b1);
                                 3'd4: r = t_ff & mdr_ff;
                                 3'd5: r = t_ff | mdr_ff;
                                 default: r = t_ff ^ mdr_ff;
                              endcase
                              if (op3 >= 3'd1 && op3 <= 3'd3) begin
                                 r = sum[15:0];
                                 flags_in = {sum[17], (r == 16'd0), r[15], sum[16]};
                              end else if (op3 >= 3'd4) begin
                                 flags_in = mcpu_pkg::zs(flags_ff, r);
                              end
                              if (op3 == 3'd3) begin
                                 st_res   = 1'b0;
                                 phase_in = mcpu_pkg::PH_FETCH;
                                 imp_in   = 4'd1;
                              end
                           end else if (imp_ff == 4'd2 && op3 != 3'd3 &&
                                        md != mcpu_pkg::MODE_REG) begin
                              mw_v = 1'b1;
                              phase_in = mcpu_pkg::PH_FETCH;
                              imp_in   = 4'd1;
                           end else begin
                              halt_in = mcpu_pkg::HALT_STRAY;
                           end
                        end
                        mcpu_pkg::CLS_ONE: begin
                           if (op4 >= 4'd6) begin
                              phase_in = mcpu_pkg::PH_FETCH;
                              imp_in   = 4'd1;
                           end else if (imp_ff == 4'd1) begin
                              st_res = 1'b1;
                              case (op4)
                                 4'd0: begin
                                    r = 16'd0;
                                    flags_in = mcpu_pkg::zs(flags_ff, r);
                                 end
                                 4'd1: begin
                                    r = ~mdr_ff;
                                    flags_in = mcpu_pkg::zs(flags_ff, r);
                                 end
                                 4'd2, 4'd3: begin
                                    sum = (op4 == 4'd2) ? mcpu_pkg::add16(mdr_ff, 16'd0, 1'b1)
                                          : mcpu_pkg::add16(mdr_ff, 16'hFFFF, 1'b0);
                                    r = sum[15:0];
                                    flags_in = {sum[17], (r == 16'd0), r[15], sum[16]};
                                 end
                                 4'd4: begin
                                    r = {mdr_ff[14:0], 1'b0};
                                    flags_in = {mdr_ff[15], flags_ff[2:0]};
                                 end
                                 default: begin
                                    r = {mdr_ff[15], mdr_ff[15:1]};
                                    flags_in = {mdr_ff[0], flags_ff[2:0]};
                                 end
                              endcase
                           end else if (imp_ff == 4'd2 && md != mcpu_pkg::MODE_REG) begin
                              mw_v = 1'b1;
                              phase_in = mcpu_pkg::PH_FETCH;
                              imp_in   = 4'd1;
                           end else begin
                              halt_in = mcpu_pkg::HALT_STRAY;
                           end
                        end
                        mcpu_pkg::CLS_BRANCH: begin
                           if (ir_ff[10]) begin
                              phase_in = mcpu_pkg::PH_FETCH;
                              imp_in   = 4'd1;
                           end else if (imp_ff != 4'd1) begin
                              halt_in = mcpu_pkg::HALT_STRAY;
                           end else begin
                              case (ir_ff[9:7])
                                 3'd0: take = 1'b1;
                                 3'd1: take = !flags_ff[mcpu_pkg::FL_Z];
                                 3'd2: take = flags_ff[mcpu_pkg::FL_Z];
                                 3'd3: take = !flags_ff[mcpu_pkg::FL_S];
                                 3'd4: take = flags_ff[mcpu_pkg::FL_C];
                                 3'd5: take = !flags_ff[mcpu_pkg::FL_C];
                                 3'd6: take = flags_ff[mcpu_pkg::FL_V];
                                 default: take = !flags_ff[mcpu_pkg::FL_V];
                              endcase
                              if (take) pc_in = pc_ff + off;
                              phase_in = mcpu_pkg::PH_FETCH;
                              imp_in   = 4'd1;
                           end
                        end
                        default: begin
                           phase_in = mcpu_pkg::PH_FETCH;
                           imp_in   = 4'd1;
                        end
                     endcase
                     if (st_res) begin
                        if (md == mcpu_pkg::MODE_REG) begin
                           gr_we = 1'b1;
                           gr_wd = r;
                           phase_in = mcpu_pkg::PH_FETCH;
                           imp_in   = 4'd1;
                        end else begin
                           mdr_in = r;
                        end
                     end
                  end
                  default: begin
                     phase_in = mcpu_pkg::PH_FETCH;
                     imp_in   = 4'd1;
                  end
               endcase
            end
         end
         default: ;
      endcase
      if (gr_we && fire) gr_vld_in[gr_wi] = 1'b1;
      if (!fire) gr_we = 1'b0;
      if (mcpu_pkg::ADDR_BITS < 16) mw_a = adr_ff & 16'((17'd1 << mcpu_pkg::ADDR_BITS) - 17'd1);
   end

   // byte bank write ports
   always_comb begin
      we_even = 1'b0; we_odd = 1'b0;
      wi_even = adr_ff[mcpu_pkg::ADDR_BITS-1:1]; wi_odd = adr_ff[mcpu_pkg::ADDR_BITS-1:1];
      wd_even = '0; wd_odd = '0;
      if (state_ff == mcpu_pkg::ST_CLEAR) begin
         we_even = 1'b1; we_odd = 1'b1; wi_even = clr_ff; wi_odd = clr_ff;
      end else if (fire && opc_ff == mcpu_pkg::OPC_LOAD) begin
         wi_even = ladr_ff[mcpu_pkg::ADDR_BITS-1:1];
         wi_odd  = ladr_ff[mcpu_pkg::ADDR_BITS-1:1];
         we_even = !ladr_ff[0];
         we_odd  = ladr_ff[0];
         wd_even = ldat_ff;
         wd_odd  = ldat_ff;
      end else if (fire && mw_v) begin
         we_even = 1'b1; we_odd = 1'b1;
         if (adr_ff[0]) begin
            wi_odd  = rd_hi;
            wd_odd  = mdr_ff[7:0];
            wi_even = rd_hi + BB'(1);
            wd_even = mdr_ff[15:8];
         end else begin
            wd_even = mdr_ff[7:0];
            wd_odd  = mdr_ff[15:8];
         end
      end
   end

   always_comb begin
      rsp_in.run_status        = halt_in;
      rsp_in.phase_now         = phase_in;
      rsp_in.impulse_now       = imp_in;
      rsp_in.program_counter   = pc_in;
      rsp_in.instruction_word  = ir_in;
      rsp_in.flag_bits         = flags_in;
      rsp_in.mem_write_valid   = mw_v;
      rsp_in.mem_write_address = mw_v ? mw_a : 16'd0;
      rsp_in.mem_write_word    = mw_v ? mw_d : 16'd0;
      rsp_in.reg_write_valid   = gr_we;
      rsp_in.reg_write_index   = gr_we ? gr_wi : 4'd0;
      rsp_in.reg_write_data    = gr_we ? gr_wd : 16'd0;
   end

   assign rsp.valid             = rsp_vld_ff;
   assign rsp.run_status        = rsp_ff.run_status;
   assign rsp.phase_now         = rsp_ff.phase_now;
   assign rsp.impulse_now       = rsp_ff.impulse_now;
   assign rsp.program_counter   = rsp_ff.program_counter;
   assign rsp.instruction_word  = rsp_ff.instruction_word;
   assign rsp.flag_bits         = rsp_ff.flag_bits;
   assign rsp.mem_write_valid   = rsp_ff.mem_write_valid;
   assign rsp.mem_write_address = rsp_ff.mem_write_address;
   assign rsp.mem_write_word    = rsp_ff.mem_write_word;
   assign rsp.reg_write_valid   = rsp_ff.reg_write_valid;
   assign rsp.reg_write_index   = rsp_ff.reg_write_index;
   assign rsp.reg_write_data    = rsp_ff.reg_write_data;

endmodule

// ===== rtl/core/mcpu_checker.sv =====
// ----------------------------------------------------------------------------
// mcpu_checker
// port-level checks on the core's step and response channels
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcpu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_run_status,
   input logic        rsp_mem_write_valid,
   input logic [15:0] rsp_mem_write_address,
   input logic [15:0] rsp_mem_write_word,
   input logic        rsp_reg_write_valid
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_req_gap, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLIES(a_mw_zero, clock, reset, rsp_valid && !rsp_mem_write_valid,
                   rsp_mem_write_address == 16'd0 && rsp_mem_write_word == 16'd0)
   `ASSERT_IMPLIES(a_rw_run, clock, reset, rsp_valid && rsp_reg_write_valid,
                   rsp_run_status == 2'd0)

endmodule

bind microsequenced_cpu16_core mcpu_checker u_mcpu_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req.valid),
   .req_ready             (req.ready),
   .rsp_valid             (rsp.valid),
   .rsp_ready             (rsp.ready),
   .rsp_run_status        (rsp.run_status),
   .rsp_mem_write_valid   (rsp.mem_write_valid),
   .rsp_mem_write_address (rsp.mem_write_address),
   .rsp_mem_write_word    (rsp.mem_write_word),
   .rsp_reg_write_valid   (rsp.reg_write_valid)
);
